### rtl/core/pcf_pkg.sv
// Shared types, constants and helper functions for the pitch complementary filter.
`default_nettype none

package pcf_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int CW           = 56;  // CORDIC x/y datapath width
    localparam int ZW           = 36;  // CORDIC angle accumulator width (Q5.30)
    localparam int SW           = 34;  // warm-up sum width

    localparam logic signed [ZW-1:0] PI_Q30 = 36'sd3373259426;

    localparam logic [SW-1:0] SUM_MAX = 34'h1_0000_0000;

    typedef enum logic [1:0] {
        REG_LOWPASS  = 2'd0,
        REG_HIGHPASS = 2'd1,
        REG_GYRO_SCL = 2'd2,
        REG_WARMUP   = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_CINIT_GO,
        ST_CINIT_WAIT,
        ST_ATAN_GO,
        ST_ATAN_WAIT,
        ST_MUL_A,
        ST_MUL_B,
        ST_EMIT
    } pcf_state_t;

    // Unit handshake between sequencer and a shared unit.
    typedef struct packed {
        logic start;
    } unit_ctl_t;

    typedef struct packed {
        logic done;
        logic busy;
    } unit_sts_t;

    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'd843314856;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043836;
            5'd3:    v = 30'd133525158;
            5'd4:    v = 30'd67021686;
            5'd5:    v = 30'd33543515;
            5'd6:    v = 30'd16775850;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194282;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048575;
            5'd11:   v = 30'd524287;
            5'd12:   v = 30'd262143;
            5'd13:   v = 30'd131071;
            5'd14:   v = 30'd65535;
            5'd15:   v = 30'd32767;
            5'd16:   v = 30'd16383;
            5'd17:   v = 30'd8191;
            5'd18:   v = 30'd4095;
            5'd19:   v = 30'd2047;
            5'd20:   v = 30'd1023;
            5'd21:   v = 30'd511;
            5'd22:   v = 30'd255;
            5'd23:   v = 30'd127;
            5'd24:   v = 30'd63;
            5'd25:   v = 30'd31;
            5'd26:   v = 30'd15;
            5'd27:   v = 30'd8;
            5'd28:   v = 30'd4;
            5'd29:   v = 30'd2;
            5'd30:   v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] sat32_36(input logic signed [35:0] v);
        logic [31:0] r;
        if (v > 36'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -36'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/pitch_complementary_filter.sv
// Top level: pitch complementary filter sequencer, state and stream ports.
`default_nettype none

// Pitch estimator fusing accelerometer X/Z and gyro Y. One sample beat in gives one
// result beat out; s_tready is low while a sample is in work. A warm-up sample needs
// neither divider nor CORDIC; the sample that ends warm-up runs the bias divider and
// then the CORDIC; a filtering sample runs the shared iterative CORDIC and then the
// multiply states. Angles are Q7.24 radians.
// The result register lets a new sample start while the previous result waits.

module pitch_complementary_filter
    import pcf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // accel_x, accel_z, gyro_y
    input  wire logic [0:0]  s_tuser,   // sample_valid
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // pitch_angle, accel_angle, gyro_angle
    output logic [0:0]       m_tuser,   // running
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_addr,
    input  wire logic [23:0] cfg_data
);

    pcf_state_t state_reg, state_next;

    logic [15:0] lp_coeff_reg, hp_coeff_reg, warmup_reg;
    logic [23:0] gscale_reg;

    logic signed [15:0] ax_reg, az_reg, gy_reg;
    logic               sv_reg;

    logic signed [SW-1:0] sum_x_reg, sum_z_reg, sum_g_reg;
    logic [15:0]          seen_reg;
    logic signed [15:0]   bias_reg;
    logic signed [31:0]   lp_reg, hp_reg, a_reg;
    logic signed [15:0]   held_x_reg, held_z_reg;
    logic signed [16:0]   held_rate_reg;
    logic                 active_reg, run_reg;
    logic signed [33:0]   lp_step_reg;
    logic signed [41:0]   rate_prod_reg;

    logic        m_tvalid_reg;
    logic [95:0] m_tdata_reg;
    logic        m_tuser_reg;

    unit_ctl_t div_ctl, cor_ctl;
    unit_sts_t div_sts, cor_sts;
    logic signed [15:0]   div_q;
    logic signed [31:0]   cor_angle;
    logic signed [SW-1:0] cor_y, cor_x;

    logic                 s_acc, emit_ok, warm_done;
    logic [15:0]          seen_inc, wc_eff;
    logic signed [SW-1:0] sx_new, sz_new, sg_new;
    logic signed [16:0]   rate_new;
    logic signed [32:0]   lp_diff;
    logic signed [49:0]   lp_prod;
    logic signed [42:0]   hp_acc;
    logic signed [59:0]   hp_prod;
    logic signed [35:0]   hp_shift, lp_sum;
    logic signed [35:0]   pitch_sum;

    function automatic logic signed [SW-1:0] sat_sum(input logic signed [SW-1:0] s,
                                                     input logic signed [15:0] v);
        logic signed [SW:0] t;
        logic signed [SW-1:0] r;
        t = {s[SW-1], s} + {{(SW-15){v[15]}}, v};
        if (t > $signed({1'b0, SUM_MAX}))
            r = $signed(SUM_MAX);
        else if (t < -$signed({1'b0, SUM_MAX}))
            r = -$signed(SUM_MAX);
        else
            r = t[SW-1:0];
        return r;
    endfunction

    assign s_acc     = s_tvalid & s_tready;
    assign emit_ok   = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    assign wc_eff    = (warmup_reg == 16'd0) ? 16'd1 : warmup_reg;
    assign seen_inc  = seen_reg + 16'd1;
    assign warm_done = seen_inc >= wc_eff;
    assign sx_new    = sat_sum(sum_x_reg, ax_reg);
    assign sz_new    = sat_sum(sum_z_reg, az_reg);
    assign sg_new    = sat_sum(sum_g_reg, gy_reg);
    assign rate_new  = 17'sd0 - ({gy_reg[15], gy_reg} - {bias_reg[15], bias_reg});

    assign lp_diff   = {a_reg[31], a_reg} - {lp_reg[31], lp_reg};
    assign lp_prod   = lp_diff * $signed({1'b0, lp_coeff_reg});
    assign hp_acc    = $signed({{3{hp_reg[31]}}, hp_reg, 8'd0})
                     + {rate_prod_reg[41], rate_prod_reg};
    assign hp_prod   = hp_acc * $signed({1'b0, hp_coeff_reg});
    assign hp_shift  = 36'((hp_prod + 60'sd8388608) >>> 24);
    assign lp_sum    = {{4{lp_reg[31]}}, lp_reg} + {{2{lp_step_reg[33]}}, lp_step_reg};
    assign pitch_sum = {{4{lp_reg[31]}}, lp_reg} + {{4{hp_reg[31]}}, hp_reg};

    // CORDIC operand select: warm-up sums or held sample
    always_comb begin
        if (state_reg == ST_CINIT_GO) begin
            cor_y = sum_z_reg;
            cor_x = -sum_x_reg;
        end else begin
            cor_y = {{(SW-16){held_z_reg[15]}}, held_z_reg};
            cor_x = -{{(SW-16){held_x_reg[15]}}, held_x_reg};
        end
    end

    pcf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .sts      (div_sts),
        .dividend (sum_g_reg),
        .divisor  (wc_eff),
        .quotient (div_q)
    );

    pcf_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (cor_ctl),
        .sts     (cor_sts),
        .y_in    (cor_y),
        .x_in    (cor_x),
        .angle   (cor_angle)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:       if (s_tvalid) state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (active_reg)
                    state_next = ST_ATAN_GO;
                else if (sv_reg && warm_done)
                    state_next = ST_DIV_GO;
                else
                    state_next = ST_EMIT;
            end
            ST_DIV_GO:     state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:   if (div_sts.done) state_next = ST_CINIT_GO;
            ST_CINIT_GO:   state_next = ST_CINIT_WAIT;
            ST_CINIT_WAIT: if (cor_sts.done) state_next = ST_EMIT;
            ST_ATAN_GO:    state_next = ST_ATAN_WAIT;
            ST_ATAN_WAIT:  if (cor_sts.done) state_next = ST_MUL_A;
            ST_MUL_A:      state_next = ST_MUL_B;
            ST_MUL_B:      state_next = ST_EMIT;
            ST_EMIT:       if (emit_ok) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready      = 1'b0;
        div_ctl.start = 1'b0;
        cor_ctl.start = 1'b0;
        case (state_reg)
            ST_IDLE:     s_tready      = 1'b1;
            ST_DIV_GO:   div_ctl.start = 1'b1;
            ST_CINIT_GO: cor_ctl.start = 1'b1;
            ST_ATAN_GO:  cor_ctl.start = 1'b1;
            default:     s_tready      = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            lp_coeff_reg  <= 16'd163;
            hp_coeff_reg  <= 16'd65373;
            gscale_reg    <= 24'd22877;
            warmup_reg    <= 16'd200;
            sum_x_reg     <= '0;
            sum_z_reg     <= '0;
            sum_g_reg     <= '0;
            seen_reg      <= '0;
            bias_reg      <= '0;
            lp_reg        <= '0;
            hp_reg        <= '0;
            held_x_reg    <= '0;
            held_z_reg    <= '0;
            held_rate_reg <= '0;
            active_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid) begin
                case (cfg_addr)
                    8'(REG_LOWPASS):  lp_coeff_reg <= cfg_data[15:0];
                    8'(REG_HIGHPASS): hp_coeff_reg <= cfg_data[15:0];
                    8'(REG_GYRO_SCL): gscale_reg   <= cfg_data;
                    8'(REG_WARMUP):   warmup_reg   <= cfg_data[15:0];
                    default: ;
                endcase
            end

            if (state_reg == ST_EMIT && emit_ok)
                m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        ax_reg <= $signed(s_tdata[15:0]);
                        az_reg <= $signed(s_tdata[31:16]);
                        gy_reg <= $signed(s_tdata[47:32]);
                        sv_reg <= s_tuser[0];
                    end
                end
                ST_DECIDE: begin
                    run_reg <= active_reg;
                    if (active_reg) begin
                        if (sv_reg) begin
                            held_x_reg    <= ax_reg;
                            held_z_reg    <= az_reg;
                            held_rate_reg <= rate_new;
                        end
                    end else if (sv_reg) begin
                        sum_x_reg <= sx_new;
                        sum_z_reg <= sz_new;
                        sum_g_reg <= sg_new;
                        seen_reg  <= seen_inc;
                    end
                end
                ST_DIV_WAIT: if (div_sts.done) bias_reg <= div_q;
                ST_CINIT_WAIT: begin
                    if (cor_sts.done) begin
                        lp_reg     <= cor_angle;
                        hp_reg     <= '0;
                        active_reg <= 1'b1;
                    end
                end
                ST_ATAN_WAIT: if (cor_sts.done) a_reg <= cor_angle;
                ST_MUL_A: begin
                    lp_step_reg   <= 34'((lp_prod + 50'sd32768) >>> 16);
                    rate_prod_reg <= held_rate_reg * $signed({1'b0, gscale_reg});
                end
                ST_MUL_B: begin
                    lp_reg <= $signed(sat32_36(lp_sum));
                    hp_reg <= $signed(sat32_36(hp_shift));
                end
                ST_EMIT: begin
                    if (emit_ok) begin
                        m_tuser_reg  <= run_reg;
                        if (run_reg)
                            m_tdata_reg <= {hp_reg, lp_reg, sat32_36(pitch_sum)};
                        else
                            m_tdata_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

`default_nettype wire

### rtl/core/pcf_div.sv
// Iterative restoring divider: signed sum by unsigned count, truncated toward zero.
`default_nettype none

module pcf_div
    import pcf_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire unit_ctl_t            ctl,
    output unit_sts_t                 sts,
    input  wire logic signed [SW-1:0] dividend,
    input  wire logic [15:0]          divisor,
    output logic signed [15:0]        quotient
);

    localparam int MW = SW - 1;

    logic          busy_reg, done_reg, neg_reg;
    logic [MW-1:0] q_reg;
    logic [16:0]   rem_reg;
    logic [5:0]    cnt_reg;
    logic [15:0]   den_reg;
    logic [16:0]   trial;
    logic [16:0]   diff;
    logic [MW-1:0] q_neg;

    assign trial = {rem_reg[15:0], q_reg[MW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign q_neg = MW'(0) - q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                neg_reg  <= dividend[SW-1];
                q_reg    <= dividend[SW-1] ? MW'(-dividend) : dividend[MW-1:0];
                rem_reg  <= '0;
                den_reg  <= divisor;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (trial >= {1'b0, den_reg}) begin
                    rem_reg <= diff;
                    q_reg   <= {q_reg[MW-2:0], 1'b1};
                end else begin
                    rem_reg <= trial;
                    q_reg   <= {q_reg[MW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(MW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = neg_reg ? $signed(q_neg[15:0]) : $signed(q_reg[15:0]);
    assign sts.done = done_reg;
    assign sts.busy = busy_reg;

endmodule

`default_nettype wire

### rtl/core/pcf_cordic.sv
// Iterative vectoring CORDIC computing atan2(y, x) in Q7.24 radians.
`default_nettype none

module pcf_cordic
    import pcf_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire unit_ctl_t            ctl,
    output unit_sts_t                 sts,
    input  wire logic signed [SW-1:0] y_in,
    input  wire logic signed [SW-1:0] x_in,
    output logic signed [31:0]        angle
);

    localparam logic [4:0] LAST = 5'(CORDIC_STEPS - 1);

    logic                 busy_reg, fin_reg, done_reg;
    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [4:0]           cnt_reg;
    logic signed [31:0]   angle_reg;

    logic signed [CW-1:0] xs_in, ys_in, xsh, ysh;
    logic signed [ZW-1:0] step, z_rnd;

    assign xs_in = $signed({{(CW-SW){x_in[SW-1]}}, x_in}) <<< 20;
    assign ys_in = $signed({{(CW-SW){y_in[SW-1]}}, y_in}) <<< 20;
    assign xsh   = x_reg >>> cnt_reg;
    assign ysh   = y_reg >>> cnt_reg;
    assign step  = $signed({6'd0, atan_q30(cnt_reg)});
    assign z_rnd = (z_reg + 36'sd32) >>> 6;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (ctl.start) begin
                cnt_reg <= '0;
                if (x_in == '0 && y_in == '0) begin
                    angle_reg <= '0;
                    done_reg  <= 1'b1;
                end else if (x_in[SW-1]) begin
                    // left half plane: pre-rotate by pi
                    z_reg    <= y_in[SW-1] ? -PI_Q30 : PI_Q30;
                    x_reg    <= -xs_in;
                    y_reg    <= -ys_in;
                    busy_reg <= 1'b1;
                end else begin
                    z_reg    <= '0;
                    x_reg    <= xs_in;
                    y_reg    <= ys_in;
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                if (!y_reg[CW-1]) begin
                    x_reg <= x_reg + ysh;
                    y_reg <= y_reg - xsh;
                    z_reg <= z_reg + step;
                end else begin
                    x_reg <= x_reg - ysh;
                    y_reg <= y_reg + xsh;
                    z_reg <= z_reg - step;
                end
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (fin_reg) begin
                angle_reg <= $signed(sat32_36(z_rnd));
                done_reg  <= 1'b1;
            end
        end
    end

    assign angle    = angle_reg;
    assign sts.done = done_reg;
    assign sts.busy = busy_reg | fin_reg;

endmodule

`default_nettype wire
